[hw/rtl/aex_pkg.sv]
// ============================================================================
// aex_pkg
// Shared types and constants of the execute stage with register file.
// ============================================================================
package aex_pkg;

    localparam int NUM_REGS    = 32;
    localparam int WORD_BITS   = 32;
    localparam int CMD_W       = 4;
    localparam int REG_FIELD_W = 5;
    localparam int REG_IDX_W   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int SHAMT_W     = $clog2(WORD_BITS);

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [REG_FIELD_W-1:0]      reg_field_t;
    typedef logic [REG_IDX_W-1:0]        reg_addr_t;

    typedef enum logic [CMD_W-1:0] {
        OP_ADD  = 4'd0,
        OP_ADDI = 4'd1,
        OP_SUB  = 4'd2,
        OP_SUBI = 4'd3,
        OP_MUL  = 4'd4,
        OP_MULI = 4'd5,
        OP_AND  = 4'd6,
        OP_OR   = 4'd7,
        OP_XOR  = 4'd8,
        OP_NOT  = 4'd9,
        OP_CMP  = 4'd10,
        OP_SHR  = 4'd11,
        OP_SHL  = 4'd12
    } cmd_t;

    // One decoded instruction as it travels through the pipeline.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        reg_field_t       dest_reg;
        reg_field_t       src_a_reg;
        reg_field_t       src_b_reg;
        word_t            immediate;
    } instr_t;

    // One result transaction.
    typedef struct packed {
        logic       wrote;
        reg_field_t written_reg;
        word_t      written_value;
    } res_t;

    // Register file read request, issued when an instruction is accepted.
    typedef struct packed {
        logic       en;
        reg_field_t a_idx;
        reg_field_t b_idx;
    } rf_rd_t;

    // Register file write request.
    typedef struct packed {
        logic       en;
        reg_field_t idx;
        word_t      data;
    } rf_wr_t;

endpackage

[hw/rtl/aex_cmd_if.sv]
// ============================================================================
// aex_cmd_if
// Valid/ready channel that carries one decoded instruction per transaction.
// ============================================================================
interface aex_cmd_if import aex_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       cmd;
    logic [REG_FIELD_W-1:0] dest_reg;
    logic [REG_FIELD_W-1:0] src_a_reg;
    logic [REG_FIELD_W-1:0] src_b_reg;
    logic signed [WORD_BITS-1:0] immediate;

    modport source (
        output valid, cmd, dest_reg, src_a_reg, src_b_reg, immediate,
        input  ready
    );

    modport sink (
        input  valid, cmd, dest_reg, src_a_reg, src_b_reg, immediate,
        output ready
    );

endinterface

[hw/rtl/aex_res_if.sv]
// ============================================================================
// aex_res_if
// Valid/ready channel that carries one register write report per transaction.
// ============================================================================
interface aex_res_if import aex_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic                   wrote;
    logic [REG_FIELD_W-1:0] written_reg;
    logic signed [WORD_BITS-1:0] written_value;

    modport source (
        output valid, wrote, written_reg, written_value,
        input  ready
    );

    modport sink (
        input  valid, wrote, written_reg, written_value,
        output ready
    );

endinterface

[hw/rtl/aex_regfile.sv]
// ============================================================================
// aex_regfile
// Register file memory with two registered read ports and one write port.
// ============================================================================
module aex_regfile import aex_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  rf_rd_t rd,
    input  rf_wr_t wr,
    output word_t  rd_a_data,
    output word_t  rd_b_data
);

    word_t               mem [NUM_REGS];
    logic [NUM_REGS-1:0] written_reg;

    word_t rd_a_word_reg;
    word_t rd_b_word_reg;
    logic  rd_a_ok_reg;
    logic  rd_b_ok_reg;

    reg_addr_t a_addr;
    reg_addr_t b_addr;
    reg_addr_t w_addr;
    logic      a_in_range;
    logic      b_in_range;
    logic      w_in_range;

    assign a_addr     = REG_IDX_W'(rd.a_idx);
    assign b_addr     = REG_IDX_W'(rd.b_idx);
    assign w_addr     = REG_IDX_W'(wr.idx);
    assign a_in_range = 32'(rd.a_idx) < NUM_REGS;
    assign b_in_range = 32'(rd.b_idx) < NUM_REGS;
    assign w_in_range = 32'(wr.idx) < NUM_REGS;

    // An entry reads as zero until it has been written since reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr.en && w_in_range)
        begin
            written_reg[w_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && w_in_range)
        begin
            mem[w_addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_a_word_reg <= mem[a_addr];
            rd_b_word_reg <= mem[b_addr];
            rd_a_ok_reg   <= a_in_range && written_reg[a_addr];
            rd_b_ok_reg   <= b_in_range && written_reg[b_addr];
        end
    end

    assign rd_a_data = rd_a_ok_reg ? rd_a_word_reg : '0;
    assign rd_b_data = rd_b_ok_reg ? rd_b_word_reg : '0;

endmodule

[hw/rtl/aex_alu.sv]
// ============================================================================
// aex_alu
// Computes the result of one instruction from its operands.
// ============================================================================
module aex_alu import aex_pkg::*; (
    input  logic [CMD_W-1:0] cmd,
    input  reg_field_t       dest_reg,
    input  word_t            op_a,
    input  word_t            op_b,
    input  word_t            immediate,
    output res_t             res
);

    logic [SHAMT_W-1:0] shamt;
    word_t              value;
    logic               supported;

    assign shamt = immediate[SHAMT_W-1:0];

    always_comb
    begin
        value     = '0;
        supported = 1'b1;
        unique case (cmd_t'(cmd))
            OP_ADD:  value = op_a + op_b;
            OP_ADDI: value = op_a + immediate;
            OP_SUB:  value = op_a - op_b;
            OP_SUBI: value = op_a - immediate;
            OP_MUL:  value = op_a * op_b;
            OP_MULI: value = op_a * immediate;
            OP_AND:  value = op_a & op_b;
            OP_OR:   value = op_a | op_b;
            OP_XOR:  value = op_a ^ op_b;
            OP_NOT:  value = ~op_a;
            OP_CMP:
            begin
                if (op_a < op_b)
                begin
                    value = WORD_BITS'(1);
                end
                else if (op_a == op_b)
                begin
                    value = '0;
                end
                else
                begin
                    value = '1;
                end
            end
            OP_SHR:  value = op_a >>> shamt;
            OP_SHL:  value = op_a << shamt;
            default: supported = 1'b0;
        endcase
    end

    // An unsupported opcode reports all zeros; a destination beyond the
    // register file still reports its index and value but writes nothing.
    always_comb
    begin
        if (supported)
        begin
            res.wrote         = 32'(dest_reg) < NUM_REGS;
            res.written_reg   = dest_reg;
            res.written_value = value;
        end
        else
        begin
            res.wrote         = 1'b0;
            res.written_reg   = '0;
            res.written_value = '0;
        end
    end

endmodule

[hw/rtl/alu_execute_with_register_file.sv]
// An accepted instruction reads the register file in stage 1, then executes
// into the output register, where its result transaction waits for the sink.
// Throughput: one instruction per cycle while the sink takes results, set by
// the two read ports and the single write port of the register file, with
// a one-entry forward path.
// Reset: the register file reads as all zeros at once through per-entry
// written flags; no clearing pass, the block accepts work right after reset.
// ============================================================================
// alu_execute_with_register_file
// Execute stage that runs decoded instructions against a register file.
// ============================================================================
module alu_execute_with_register_file import aex_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    aex_cmd_if.sink   instr,
    aex_res_if.source result
);

    // Stage 1 holds the accepted instruction while its operands come back
    // from the register file memory.
    logic   s1_valid_reg;
    instr_t s1_instr_reg;

    // Output register: a finished result waits here for the sink.
    logic   out_valid_reg;
    res_t   out_res_reg;

    // Forward path: the write that took place at the same edge at which the
    // stage 1 instruction read the memory. The memory returns the old word
    // in that case, so the new one is held here and substituted.
    logic       fwd_valid_reg;
    reg_field_t fwd_idx_reg;
    word_t      fwd_value_reg;

    logic   accept;
    logic   advance;
    instr_t in_instr;
    rf_rd_t rf_rd;
    rf_wr_t rf_wr;
    word_t  rd_a_data;
    word_t  rd_b_data;
    word_t  op_a;
    word_t  op_b;
    res_t   alu_res;

    // Stage 1 moves on whenever the output register is free or being drained.
    assign advance     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign instr.ready = !s1_valid_reg || advance;
    assign accept      = instr.valid && instr.ready;

    assign in_instr.cmd       = instr.cmd;
    assign in_instr.dest_reg  = instr.dest_reg;
    assign in_instr.src_a_reg = instr.src_a_reg;
    assign in_instr.src_b_reg = instr.src_b_reg;
    assign in_instr.immediate = instr.immediate;

    assign rf_rd.en    = accept;
    assign rf_rd.a_idx = instr.src_a_reg;
    assign rf_rd.b_idx = instr.src_b_reg;

    // The stage 1 instruction writes its destination as it leaves stage 1.
    assign rf_wr.en   = advance && alu_res.wrote;
    assign rf_wr.idx  = alu_res.written_reg;
    assign rf_wr.data = alu_res.written_value;

    aex_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd        (rf_rd),
        .wr        (rf_wr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    assign op_a = (fwd_valid_reg && fwd_idx_reg == s1_instr_reg.src_a_reg)
                  ? fwd_value_reg : rd_a_data;
    assign op_b = (fwd_valid_reg && fwd_idx_reg == s1_instr_reg.src_b_reg)
                  ? fwd_value_reg : rd_b_data;

    aex_alu u_alu (
        .cmd       (s1_instr_reg.cmd),
        .dest_reg  (s1_instr_reg.dest_reg),
        .op_a      (op_a),
        .op_b      (op_b),
        .immediate (s1_instr_reg.immediate),
        .res       (alu_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (instr.ready)
            begin
                s1_valid_reg <= instr.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // Only the write coincident with the read can be missed: every
            // older instruction has written by then.
            if (accept)
            begin
                fwd_valid_reg <= rf_wr.en;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_instr_reg  <= in_instr;
            fwd_idx_reg   <= rf_wr.idx;
            fwd_value_reg <= rf_wr.data;
        end
        if (advance)
        begin
            out_res_reg <= alu_res;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.wrote         = out_res_reg.wrote;
    assign result.written_reg   = out_res_reg.written_reg;
    assign result.written_value = out_res_reg.written_value;

endmodule

[hw/rtl/aex_checker.sv]
// ============================================================================
// aex_checker
// Port-level checks of the execute stage, attached to the top level by bind.
// ============================================================================
module aex_checker import aex_pkg::*; (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic                   out_wrote,
    input logic [REG_FIELD_W-1:0] out_written_reg,
    input logic [WORD_BITS-1:0]   out_written_value
);

    // The input side stalls only behind a result that the sink refuses.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled while the output side could drain");

    // Acceptance into an empty output side leads to a valid output side.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid) |=> ##1 out_valid)
        else $error("result transaction did not appear on time");

    // With every destination index in range, a report without a write can
    // only come from an unsupported opcode, which reports all zeros.
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (NUM_REGS >= (1 << REG_FIELD_W) && out_valid && !out_wrote)
        |-> (out_written_reg == '0 && out_written_value == '0))
        else $error("report without a write carries a nonzero payload");

    // A refused result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_wrote)
        && $stable(out_written_reg) && $stable(out_written_value)))
        else $error("result transaction changed while stalled");

endmodule

bind alu_execute_with_register_file aex_checker u_aex_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (instr.valid),
    .in_ready          (instr.ready),
    .out_valid         (result.valid),
    .out_ready         (result.ready),
    .out_wrote         (result.wrote),
    .out_written_reg   (result.written_reg),
    .out_written_value (result.written_value)
);

[bench/tb_alu_execute_with_register_file.sv]
// ============================================================================
// tb_alu_execute_with_register_file
// Self-checking bench for the execute stage with a 32-entry register file.
// Decoded instructions are sent over the valid/ready instruction channel.
// Each accepted transaction runs through a bench-side model of the register
// file and ALU, and the expected write report is queued. Every accepted
// result transaction is checked field by field against the oldest queued
// report. Both channels idle at random, and one phase holds the result
// channel off long enough to back up the whole pipeline.
// ============================================================================
module tb_alu_execute_with_register_file;

    import aex_pkg::*;

    // Opcodes above the last defined one must be flagged and write nothing.
    localparam logic [CMD_W-1:0] FIRST_UNUSED_CMD = 4'd13;

    // Slowest correct run is about 2000 transactions, each with at most the
    // longest sender gap, longest receiver stall and pipeline latency, plus
    // the long hold-off. The limit is several times that.
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int MAX_ERR_LINES = 30;

    logic clk;
    logic rst_n;

    aex_cmd_if instr_ch ();
    aex_res_if result_ch ();

    alu_execute_with_register_file DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .result (result_ch)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------

    // Bench copy of the architectural register file. It is updated at the
    // moment an instruction transaction is accepted, so it always matches the
    // file as seen by the next accepted instruction.
    word_t arch_regs [NUM_REGS];

    // Write reports that have been predicted but not yet seen on the output.
    res_t pending_writes [$];

    // Idling controls. The test tasks switch these to get stretches with
    // and without gaps on each side.
    bit sender_idles    = 1'b0;
    bit receiver_stalls = 1'b0;
    int long_hold_cycles = 0;

    int fail_count      = 0;
    int cycle_count     = 0;
    int sent_count      = 0;
    int checked_count   = 0;
    int no_write_count  = 0;
    int back_stall_seen = 0;
    int op_seen [16];

    // ------------------------------------------------------------------------
    // Clock, timeout
    // ------------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Register file and ALU model
    // ------------------------------------------------------------------------

    // Executes one instruction against the bench register file and returns
    // the write report that the block must produce for it.
    function automatic res_t execute_instr(input instr_t t);
        word_t  a;
        word_t  b;
        word_t  v;
        logic [SHAMT_W-1:0] shamt;
        logic   supported;
        res_t   r;

        // Out-of-range source indexes read as zero.
        a = (t.src_a_reg < NUM_REGS) ? arch_regs[t.src_a_reg] : '0;
        b = (t.src_b_reg < NUM_REGS) ? arch_regs[t.src_b_reg] : '0;
        shamt = t.immediate[SHAMT_W-1:0];
        supported = 1'b1;
        v = '0;

        case (t.cmd)
            OP_ADD:  v = a + b;
            OP_ADDI: v = a + t.immediate;
            OP_SUB:  v = a - b;
            OP_SUBI: v = a - t.immediate;
            OP_MUL:  v = a * b;
            OP_MULI: v = a * t.immediate;
            OP_AND:  v = a & b;
            OP_OR:   v = a | b;
            OP_XOR:  v = a ^ b;
            OP_NOT:  v = ~a;
            // Three-way compare: 1 when a is less, -1 when a is greater.
            OP_CMP:  v = (a < b) ? word_t'(1) : ((a == b) ? word_t'(0) : word_t'(-1));
            OP_SHR:  v = a >>> shamt;
            OP_SHL:  v = a << shamt;
            default: supported = 1'b0;
        endcase

        if (!supported)
        begin
            r = '0;
        end
        else
        begin
            r.written_reg   = t.dest_reg;
            r.written_value = v;
            r.wrote         = (t.dest_reg < NUM_REGS);
            if (r.wrote)
                arch_regs[t.dest_reg] = v;
        end
        return r;
    endfunction

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Instruction sender
    // ------------------------------------------------------------------------

    // Offers one instruction and returns at the edge where it was accepted.
    // Valid is only lowered when a gap follows, so back-to-back transactions
    // keep valid high without a same-step low/high pair.
    task automatic send_instr(input instr_t t);
        int gap;
        gap = sender_idles ? pick_gap() : 0;
        if (gap > 0)
        begin
            instr_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        instr_ch.valid     <= 1'b1;
        instr_ch.cmd       <= t.cmd;
        instr_ch.dest_reg  <= t.dest_reg;
        instr_ch.src_a_reg <= t.src_a_reg;
        instr_ch.src_b_reg <= t.src_b_reg;
        instr_ch.immediate <= t.immediate;
        do
        begin
            @(posedge clk);
            if (!instr_ch.ready)
                back_stall_seen++;
        end
        while (!instr_ch.ready);
        pending_writes.push_back(execute_instr(t));
        op_seen[t.cmd]++;
        sent_count++;
    endtask

    task automatic issue(input logic [CMD_W-1:0] op, input int d, input int a,
                         input int b, input word_t imm);
        instr_t t;
        t.cmd       = op;
        t.dest_reg  = reg_field_t'(d);
        t.src_a_reg = reg_field_t'(a);
        t.src_b_reg = reg_field_t'(b);
        t.immediate = imm;
        send_instr(t);
    endtask

    // Random immediate that lands on the extremes and small values often.
    function automatic word_t random_imm();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return word_t'($urandom_range(0, 64)) - 32;
            3:       return -1;
            default: return word_t'($urandom);
        endcase
    endfunction

    // Random instruction. Register indexes are drawn from 0..reg_span so a
    // small span produces dense read-after-write chains.
    function automatic instr_t random_instr(input int reg_span);
        instr_t t;
        if ($urandom_range(0, 19) == 0)
            t.cmd = FIRST_UNUSED_CMD + CMD_W'($urandom_range(0, 2));
        else
            t.cmd = CMD_W'($urandom_range(OP_ADD, OP_SHL));
        t.dest_reg  = reg_field_t'($urandom_range(0, reg_span));
        t.src_a_reg = reg_field_t'($urandom_range(0, reg_span));
        t.src_b_reg = reg_field_t'($urandom_range(0, reg_span));
        t.immediate = random_imm();
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // Result receiver: drives ready, with random stalls and a long hold-off
    // that a test can request through long_hold_cycles.
    // ------------------------------------------------------------------------

    initial
    begin
        int n;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_cycles > 0)
            begin
                n = long_hold_cycles;
                long_hold_cycles = 0;
                result_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else if (receiver_stalls && ($urandom_range(0, 3) == 0))
            begin
                n = pick_gap();
                result_ch.ready <= 1'b0;
                repeat ((n > 0) ? n : 1) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_writes.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_ERR_LINES)
                    $display("%0t: unexpected result transaction reg=%0d value=%0d",
                             $time, result_ch.written_reg, result_ch.written_value);
            end
            else
            begin
                want = pending_writes.pop_front();
                checked_count++;
                if (!want.wrote)
                    no_write_count++;
                if (result_ch.wrote !== want.wrote)
                begin
                    fail_count++;
                    if (fail_count <= MAX_ERR_LINES)
                        $display("%0t: wrote mismatch, expected %0b actual %0b",
                                 $time, want.wrote, result_ch.wrote);
                end
                if (result_ch.written_reg !== want.written_reg)
                begin
                    fail_count++;
                    if (fail_count <= MAX_ERR_LINES)
                        $display("%0t: written_reg mismatch, expected %0d actual %0d",
                                 $time, want.written_reg, result_ch.written_reg);
                end
                if (result_ch.written_value !== want.written_value)
                begin
                    fail_count++;
                    if (fail_count <= MAX_ERR_LINES)
                        $display("%0t: written_value mismatch, expected %0d actual %0d",
                                 $time, want.written_value, result_ch.written_value);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked instructions: registers read as zero after reset, every
    // operation but NOT with operands at the extremes of the word, wrap-around on
    // add, subtract and multiply, all three compare outcomes, shift amounts
    // that use only the low five immediate bits, unsupported opcodes that
    // must leave the file untouched, and back-to-back writes to the same
    // register that the forward path has to cover.
    task automatic test_directed_ops();
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        issue(OP_ADD,   3,  1,  2, 0);
        issue(OP_ADDI,  1,  0,  0, 32'sh7FFF_FFFF);
        issue(OP_ADDI,  2,  0,  0, 32'sh8000_0000);
        issue(OP_ADD,   4,  1,  1, 0);
        issue(OP_SUB,   5,  2,  1, 0);
        issue(OP_SUBI,  6,  2,  0, 1);
        issue(OP_MUL,   7,  1,  1, 0);
        issue(OP_MULI,  8,  2,  0, -1);
        issue(OP_AND,   9,  1,  2, 0);
        issue(OP_OR,   10,  1,  2, 0);
        issue(OP_XOR,  11, 10,  1, 0);
        issue(OP_NOT,  12,  0,  0, 0);
        issue(OP_CMP,  13,  1,  2, 0);
        issue(OP_CMP,  14,  2,  1, 0);
        issue(OP_CMP,  15,  1,  1, 0);
        issue(OP_SHR,  16,  2,  0, 31);
        issue(OP_SHR,  17,  1,  0, 32'shFFFF_FFE1);
        issue(OP_SHL,  18, 12,  0, 31);
        issue(OP_SHL,  19,  1,  0, 32);
        issue(FIRST_UNUSED_CMD,                1, 2, 3, -1);
        issue(CMD_W'(FIRST_UNUSED_CMD + 4'd1), 1, 2, 3, 32'sh7FFF_FFFF);
        issue(CMD_W'(FIRST_UNUSED_CMD + 4'd2), 1, 2, 3, 32'sh8000_0000);
        issue(OP_ADD,  20,  1,  0, 0);
        issue(OP_ADDI, 31, 31,  0, 5);
        issue(OP_ADDI, 31, 31,  0, 5);
    endtask

    // Dense dependency chains on a handful of registers, sent back to back,
    // so nearly every instruction reads a result that is still in flight.
    task automatic test_dependency_chains(input int count);
        for (int i = 0; i < count; i++)
        begin
            receiver_stalls = (i >= count / 2);
            send_instr(random_instr(3));
        end
    endtask

    // Broad random traffic over the whole register file and all opcodes.
    // Idling on each side switches every 150 transactions so there are
    // stretches of full rate as well as stretches with gaps on both sides.
    task automatic test_random_traffic(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
            begin
                sender_idles    = ((i / 150) % 4) != 0;
                receiver_stalls = ((i / 150) % 4) >= 2;
            end
            send_instr(random_instr(($urandom_range(0, 2) == 0) ? 7 : 31));
        end
    endtask

    // The result side is held off for a long stretch while instructions keep
    // coming at full rate, so the pipeline fills and the input must stall.
    task automatic test_output_backpressure(input int count);
        sender_idles     = 1'b0;
        receiver_stalls  = 1'b0;
        long_hold_cycles = 300;
        for (int i = 0; i < count; i++)
            send_instr(random_instr(7));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        instr_ch.valid     = 1'b0;
        instr_ch.cmd       = '0;
        instr_ch.dest_reg  = '0;
        instr_ch.src_a_reg = '0;
        instr_ch.src_b_reg = '0;
        instr_ch.immediate = '0;
        for (int i = 0; i < NUM_REGS; i++)
            arch_regs[i] = '0;
        for (int i = 0; i < 16; i++)
            op_seen[i] = 0;

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_ops();
        test_dependency_chains(400);
        test_output_backpressure(80);
        test_random_traffic(1400);

        instr_ch.valid <= 1'b0;
        while (pending_writes.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d instructions (unsupported opcodes: %0d), checked %0d results",
                 sent_count,
                 op_seen[FIRST_UNUSED_CMD] + op_seen[CMD_W'(FIRST_UNUSED_CMD + 4'd1)]
                 + op_seen[CMD_W'(FIRST_UNUSED_CMD + 4'd2)],
                 checked_count);
        $display("Results without a write: %0d, input stall cycles seen: %0d",
                 no_write_count, back_stall_seen);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
